@@ rtl/mfw_pkg.sv @@
// mfw_pkg: shared widths, constants and types for the mitchell filter weight core
// no dependencies; imported by the interfaces and every rtl module of the block
package mfw_pkg;

   localparam int OFF_W         = 16;
   localparam int CFG_W         = 16;
   localparam int WGT_W         = 18;
   localparam int DEF_FRAC_BITS = 12;

   // bounds: |k| < 2^21 and each horner step at most doubles and then adds a k, so |p| < 2^25
   localparam int COEF_W = 24;
   localparam int POLY_W = 27;

   localparam int AXIS_STG = 6;
   localparam int COMB_STG = 4;
   localparam int NUM_STG  = AXIS_STG + COMB_STG;

   // divide by nine of the rounded quotient: u * ceil(2^24 / 9) >> 24, exact for u < 2^21
   localparam int             U_W    = 21;
   localparam int             DIV_SH = 24;
   localparam logic [U_W-1:0] DIV_M  = 21'd1864136;

   localparam int SAT_POS = 36 * 131072;
   localparam int SAT_NEG = 36 * 131073;

   localparam logic signed [WGT_W-1:0] W_MAX = 18'sh1ffff;
   localparam logic signed [WGT_W-1:0] W_MIN = 18'sh20000;

   localparam logic [CFG_W-1:0] B_RESET   = 16'd1365;
   localparam logic [CFG_W-1:0] C_RESET   = 16'd1365;
   localparam logic [CFG_W-1:0] INV_RESET = 16'd1024;

   typedef enum logic [1:0] {
      REG_B_COEFF,
      REG_C_COEFF,
      REG_INV_X_WIDTH,
      REG_INV_Y_WIDTH
   } csr_idx_type;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [POLY_W-1:0] poly_type;

   typedef struct packed {
      coef_type k3;
      coef_type k2;
      coef_type k1;
      coef_type k0;
   } coef_set_type;

endpackage

@@ rtl/mfw_if.sv @@
// mfw_if: valid/ready channels of the filter weight core (offset request, weight response)
// depends on mfw_pkg for field widths
interface mfw_req_if;
   import mfw_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OFF_W-1:0] x_offset;
   logic signed [OFF_W-1:0] y_offset;
   modport source (output valid, output x_offset, output y_offset, input ready);
   modport sink (input valid, input x_offset, input y_offset, output ready);
endinterface

interface mfw_rsp_if;
   import mfw_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [WGT_W-1:0] weight;
   modport source (output valid, output weight, input ready);
   modport sink (input valid, input weight, output ready);
endinterface

@@ rtl/mitchell_filter_weight_core.sv @@
// mitchell_filter_weight_core: top level, config registers, stage valid chain, two axis units
// depends on mfw_pkg, mfw_if, mfw_axis and mfw_comb
//
// usage:
//   req carries one sample offset pair (x_offset, y_offset, signed fixed point) per transfer;
//   rsp carries the separable mitchell-netravali weight, signed q1.16, saturated.
//   csr_we/csr_idx/csr_wdata write b_coeff, c_coeff, inv_x_width, inv_y_width; write only
//   while no transfer is in flight.
// throughput: one transfer per cycle while rsp.ready is high, set by the ten-stage pipeline
//   in which every multiplier is followed by a register.
// stall: when rsp.ready is low, stages fill up behind the output register; req.ready drops
//   only once every stage holds an item, and bubbles close up as the pipe refills.
// reset: synchronous, active high; empties the pipeline and loads b = c = 1/3 and both
//   reciprocal widths = 1024 (0.25 at 12 fraction bits).
module mitchell_filter_weight_core #(
   parameter int FRAC_BITS = mfw_pkg::DEF_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   mfw_req_if.sink                     req,
   mfw_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  mfw_pkg::csr_idx_type        csr_idx,
   input  logic [mfw_pkg::CFG_W-1:0]   csr_wdata
);
   import mfw_pkg::*;

   localparam coef_type ONE = coef_type'(1) << FRAC_BITS;

   logic [CFG_W-1:0]   b_ff, c_ff, inv_x_ff, inv_y_ff;
   logic [NUM_STG-1:0] valid_ff, valid_in;
   logic [NUM_STG-1:0] stg_en;
   coef_type           bb, cc;
   coef_set_type       inner_k, outer_k;
   poly_type           px, py;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff     <= B_RESET;
         c_ff     <= C_RESET;
         inv_x_ff <= INV_RESET;
         inv_y_ff <= INV_RESET;
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_B_COEFF:     b_ff     <= csr_wdata;
            REG_C_COEFF:     c_ff     <= csr_wdata;
            REG_INV_X_WIDTH: inv_x_ff <= csr_wdata;
            REG_INV_Y_WIDTH: inv_y_ff <= csr_wdata;
            default:         b_ff     <= b_ff;
         endcase
      end
   end

   // kernel coefficients, six times the published polynomials
   always_comb begin
      bb         = coef_type'($signed(b_ff));
      cc         = coef_type'($signed(c_ff));
      outer_k.k3 = -bb - cc * coef_type'(6);
      outer_k.k2 = bb * coef_type'(6) + cc * coef_type'(30);
      outer_k.k1 = -(bb * coef_type'(12)) - cc * coef_type'(48);
      outer_k.k0 = bb * coef_type'(8) + cc * coef_type'(24);
      inner_k.k3 = ONE * coef_type'(12) - bb * coef_type'(9) - cc * coef_type'(6);
      inner_k.k2 = -(ONE * coef_type'(18)) + bb * coef_type'(12) + cc * coef_type'(6);
      inner_k.k1 = '0;
      inner_k.k0 = ONE * coef_type'(6) - bb * coef_type'(2);
   end

   // a stage advances when it is empty or the one after it advances
   always_comb begin
      stg_en[NUM_STG-1] = !valid_ff[NUM_STG-1] || rsp.ready;
      for (int i = NUM_STG - 2; i >= 0; i--) begin
         stg_en[i] = !valid_ff[i] || stg_en[i+1];
      end
      for (int i = 0; i < NUM_STG; i++) begin
         if (stg_en[i]) begin
            valid_in[i] = (i == 0) ? req.valid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   mfw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock     (clock),
      .stg_en    (stg_en[AXIS_STG-1:0]),
      .offset    (req.x_offset),
      .inv_width (inv_x_ff),
      .inner_k   (inner_k),
      .outer_k   (outer_k),
      .p_out     (px)
   );

   mfw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock     (clock),
      .stg_en    (stg_en[AXIS_STG-1:0]),
      .offset    (req.y_offset),
      .inv_width (inv_y_ff),
      .inner_k   (inner_k),
      .outer_k   (outer_k),
      .p_out     (py)
   );

   mfw_comb #(.FRAC_BITS(FRAC_BITS)) u_comb (
      .clock  (clock),
      .stg_en (stg_en[NUM_STG-1:AXIS_STG]),
      .px     (px),
      .py     (py),
      .weight (rsp.weight)
   );

   assign req.ready = stg_en[0];
   assign rsp.valid = valid_ff[NUM_STG-1];

endmodule

@@ rtl/mfw_axis.sv @@
// mfw_axis: six-stage per-axis datapath, scaled offset to six times the cubic kernel value
// depends on mfw_pkg; stage enables come from the top level valid chain
module mfw_axis #(
   parameter int FRAC_BITS = mfw_pkg::DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic [mfw_pkg::AXIS_STG-1:0]          stg_en,
   input  logic signed [mfw_pkg::OFF_W-1:0]      offset,
   input  logic [mfw_pkg::CFG_W-1:0]             inv_width,
   input  mfw_pkg::coef_set_type                 inner_k,
   input  mfw_pkg::coef_set_type                 outer_k,
   output mfw_pkg::poly_type                     p_out
);
   import mfw_pkg::*;

   localparam int PROD_W = OFF_W + CFG_W + 1;
   localparam int DBL_W  = PROD_W + 1;
   localparam int MUL_W  = POLY_W + FRAC_BITS + 2;

   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]         mag;
   logic [DBL_W-1:0]          dbl;
   logic                      cut_arg;
   logic                      outer_arg;
   logic [FRAC_BITS:0]        a2_ff, a2_in, a3_ff, a4_ff;
   logic                      cut2_ff, cut2_in, cut3_ff, cut4_ff, cut5_ff;
   coef_set_type              k2_ff, k2_in, k3_ff, k4_ff, k5_ff;
   logic signed [MUL_W-1:0]   m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in;
   logic signed [FRAC_BITS+1:0] a3_s, a4_s, a5_s;
   poly_type                  p1, p2;
   poly_type                  p_ff, p_in;

   // stage 1: scale offset by reciprocal width
   assign prod_in = PROD_W'(offset) * $signed({1'b0, inv_width});

   // stage 2: doubled magnitude, range cut, cubic select
   always_comb begin
      mag       = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      dbl       = {mag, 1'b0};
      cut_arg   = (dbl >> (2 * FRAC_BITS + 1)) != '0;
      a2_in     = dbl[2*FRAC_BITS:FRAC_BITS];
      outer_arg = a2_in[FRAC_BITS] && (a2_in[FRAC_BITS-1:0] != '0);
      cut2_in   = cut_arg;
      k2_in     = outer_arg ? outer_k : inner_k;
   end

   // stages 3 to 6: horner evaluation
   assign a3_s  = {1'b0, a2_ff};
   assign a4_s  = {1'b0, a3_ff};
   assign a5_s  = {1'b0, a4_ff};
   assign m1_in = k2_ff.k3 * a3_s;
   assign p1    = poly_type'(m1_ff >>> FRAC_BITS) + poly_type'(k3_ff.k2);
   assign m2_in = p1 * a4_s;
   assign p2    = poly_type'(m2_ff >>> FRAC_BITS) + poly_type'(k4_ff.k1);
   assign m3_in = p2 * a5_s;
   assign p_in  = cut5_ff ? '0 : poly_type'(m3_ff >>> FRAC_BITS) + poly_type'(k5_ff.k0);

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         prod_ff <= prod_in;
      end
      if (stg_en[1]) begin
         a2_ff   <= a2_in;
         cut2_ff <= cut2_in;
         k2_ff   <= k2_in;
      end
      if (stg_en[2]) begin
         m1_ff   <= m1_in;
         a3_ff   <= a2_ff;
         cut3_ff <= cut2_ff;
         k3_ff   <= k2_ff;
      end
      if (stg_en[3]) begin
         m2_ff   <= m2_in;
         a4_ff   <= a3_ff;
         cut4_ff <= cut3_ff;
         k4_ff   <= k3_ff;
      end
      if (stg_en[4]) begin
         m3_ff   <= m3_in;
         cut5_ff <= cut4_ff;
         k5_ff   <= k4_ff;
      end
      if (stg_en[5]) begin
         p_ff <= p_in;
      end
   end

   assign p_out = p_ff;

endmodule

@@ rtl/mfw_comb.sv @@
// mfw_comb: four-stage combine, axis product, rounded divide by 36, saturation
// depends on mfw_pkg; stage enables come from the top level valid chain
module mfw_comb #(
   parameter int FRAC_BITS = mfw_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic [mfw_pkg::COMB_STG-1:0]     stg_en,
   input  mfw_pkg::poly_type                px,
   input  mfw_pkg::poly_type                py,
   output logic signed [mfw_pkg::WGT_W-1:0] weight
);
   import mfw_pkg::*;

   localparam int Q_W   = 2 * POLY_W;
   localparam int SH    = 2 * FRAC_BITS - 16;
   localparam int R_W   = U_W + U_W;
   localparam logic [Q_W:0] RND     = (Q_W + 1)'(18) << SH;
   localparam logic [Q_W:0] LIM_POS = (Q_W + 1)'(SAT_POS);
   localparam logic [Q_W:0] LIM_NEG = (Q_W + 1)'(SAT_NEG);

   logic signed [Q_W-1:0]   q_ff, q_in;
   logic [Q_W-1:0]          mag;
   logic [Q_W:0]            t;
   logic                    neg8_ff, neg8_in, sat8_ff, sat8_in;
   logic [U_W-1:0]          u_ff, u_in;
   logic [R_W-1:0]          r_prod_ff, r_prod_in;
   logic                    neg9_ff, sat9_ff;
   logic [WGT_W-1:0]        r;
   logic signed [WGT_W-1:0] weight_ff, weight_in;

   assign q_in = px * py;

   // rounded quotient by 36 << SH: shift out the power of two, keep the part below saturation
   always_comb begin
      neg8_in = q_ff[Q_W-1];
      mag     = neg8_in ? Q_W'(-q_ff) : Q_W'(q_ff);
      t       = ({1'b0, mag} + RND) >> SH;
      sat8_in = neg8_in ? (t >= LIM_NEG) : (t >= LIM_POS);
      u_in    = t[U_W+1:2];
   end

   assign r_prod_in = R_W'(u_ff) * R_W'(DIV_M);

   always_comb begin
      r = r_prod_ff[DIV_SH+WGT_W-1:DIV_SH];
      if (sat9_ff) begin
         weight_in = neg9_ff ? W_MIN : W_MAX;
      end else begin
         weight_in = neg9_ff ? $signed(WGT_W'(~r + 1'b1)) : $signed(r);
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         q_ff <= q_in;
      end
      if (stg_en[1]) begin
         neg8_ff <= neg8_in;
         sat8_ff <= sat8_in;
         u_ff    <= u_in;
      end
      if (stg_en[2]) begin
         r_prod_ff <= r_prod_in;
         neg9_ff   <= neg8_ff;
         sat9_ff   <= sat8_ff;
      end
      if (stg_en[3]) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

@@ dv/mitchell_filter_weight_core_test.sv @@
// mitchell_filter_weight_core_test: self-checking testbench for the filter weight core
// depends on mfw_pkg, mfw_if and mitchell_filter_weight_core; predicts each weight in place
// and checks every rsp transfer in order under random req gaps and rsp stalls
module mitchell_filter_weight_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mfw_pkg::*;

   localparam int     FRAC    = DEF_FRAC_BITS;
   localparam longint UNIT    = longint'(1) << FRAC;
   localparam longint WGT_DIV = longint'(36) << (2 * FRAC - 16);
   localparam int     PHASE_ITEMS = 60;

   typedef logic signed [WGT_W-1:0] weight_type;

   typedef struct {
      logic signed [OFF_W-1:0] x;
      logic signed [OFF_W-1:0] y;
   } offset_pair_type;

   typedef struct {
      offset_pair_type pair;
      weight_type      weight;
   } weight_check_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_idx_type         csr_idx;
   logic [CFG_W-1:0]    csr_wdata;

   mfw_req_if req_if ();
   mfw_rsp_if rsp_if ();

   mitchell_filter_weight_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // local copy of the kernel registers
   logic [CFG_W-1:0] cfg_b;
   logic [CFG_W-1:0] cfg_c;
   logic [CFG_W-1:0] cfg_inv_x;
   logic [CFG_W-1:0] cfg_inv_y;

   offset_pair_type  pending_pairs[$];
   weight_check_type expected_weights[$];
   int               pairs_outstanding;
   int               mismatches;

   int               send_gap;
   int               send_burst;
   int               recv_stall;
   int               recv_burst;
   offset_pair_type  next_pair;
   weight_check_type oldest;

   always #2 clock = ~clock;

   // six times the axis value, q.FRAC
   function automatic longint axis_poly(input logic signed [OFF_W-1:0] off,
                                        input logic [CFG_W-1:0] inv);
      longint off_l, inv_l, mag, arg, b, c, k3, k2, k1, k0, p;
      off_l = off;
      inv_l = inv;
      mag = off_l * inv_l;
      if (mag < 0) mag = -mag;
      arg = (mag * 2) >>> FRAC;
      if (arg >= 2 * UNIT) return 0;
      b = $signed(cfg_b);
      c = $signed(cfg_c);
      if (arg > UNIT) begin
         k3 = -b - 6 * c;
         k2 = 6 * b + 30 * c;
         k1 = -12 * b - 48 * c;
         k0 = 8 * b + 24 * c;
      end else begin
         k3 = 12 * UNIT - 9 * b - 6 * c;
         k2 = -18 * UNIT + 12 * b + 6 * c;
         k1 = 0;
         k0 = 6 * UNIT - 2 * b;
      end
      p = ((k3 * arg) >>> FRAC) + k2;
      p = ((p * arg) >>> FRAC) + k1;
      p = ((p * arg) >>> FRAC) + k0;
      return p;
   endfunction

   function automatic weight_type mitchell_weight(input offset_pair_type s);
      longint q, mag, r;
      q = axis_poly(s.x, cfg_inv_x) * axis_poly(s.y, cfg_inv_y);
      mag = (q < 0) ? -q : q;
      r = (mag + WGT_DIV / 2) / WGT_DIV;
      if (q < 0) return (r > -longint'(W_MIN)) ? W_MIN : weight_type'(-r);
      return (r > longint'(W_MAX)) ? W_MAX : weight_type'(r);
   endfunction

   // mostly zero, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offset bound that keeps the scaled argument below two
   function automatic int support_limit(input logic [CFG_W-1:0] inv);
      int lim;
      if (inv == 0) return 32767;
      lim = ((1 << 24) - 1) / inv;
      return (lim > 32767) ? 32767 : lim;
   endfunction

   function automatic logic signed [OFF_W-1:0] random_offset(input logic [CFG_W-1:0] inv);
      int lim;
      lim = support_limit(inv);
      if ($urandom_range(0, 9) < 7) return OFF_W'($urandom_range(0, 2 * lim) - lim);
      return OFF_W'($urandom());
   endfunction

   task automatic push_pair(input int x, input int y);
      offset_pair_type s;
      s.x = OFF_W'(x);
      s.y = OFF_W'(y);
      pending_pairs.push_back(s);
      pairs_outstanding++;
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= val;
      case (idx)
         REG_B_COEFF:     cfg_b     = val;
         REG_C_COEFF:     cfg_c     = val;
         REG_INV_X_WIDTH: cfg_inv_x = val;
         REG_INV_Y_WIDTH: cfg_inv_y = val;
      endcase
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pairs_outstanding != 0);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] c,
                            input logic [CFG_W-1:0] ix, input logic [CFG_W-1:0] iy);
      offset_pair_type s;
      wait_drained();
      write_reg(REG_B_COEFF, b);
      write_reg(REG_C_COEFF, c);
      write_reg(REG_INV_X_WIDTH, ix);
      write_reg(REG_INV_Y_WIDTH, iy);
      @(posedge clock);
      csr_we <= 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         s.x = random_offset(cfg_inv_x);
         s.y = random_offset(cfg_inv_y);
         push_pair(s.x, s.y);
      end
   endtask

   task automatic report_mismatch(input offset_pair_type s, input weight_type want,
                                  input weight_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("weight mismatch x=%0d y=%0d expected %0d got %0d",
                  s.x, s.y, want, got);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     = 0;
         send_burst   = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            oldest.pair.x  = req_if.x_offset;
            oldest.pair.y  = req_if.y_offset;
            oldest.weight  = mitchell_weight(oldest.pair);
            expected_weights.push_back(oldest);
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               next_pair = pending_pairs.pop_front();
               req_if.x_offset <= next_pair.x;
               req_if.y_offset <= next_pair.y;
               req_if.valid    <= 1'b1;
               if (send_burst > 0) begin
                  send_burst--;
               end else begin
                  send_gap = pick_gap();
                  if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 60);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_stall   = 0;
         recv_burst   = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_weights.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected weight transfer %0d", rsp_if.weight);
            end else begin
               oldest = expected_weights.pop_front();
               pairs_outstanding--;
               if (rsp_if.weight !== oldest.weight)
                  report_mismatch(oldest.pair, oldest.weight, rsp_if.weight);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (recv_burst > 0) begin
               recv_burst--;
            end else begin
               recv_stall = pick_gap();
               if ($urandom_range(0, 49) == 0) recv_burst = $urandom_range(20, 60);
            end
         end
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_idx           = REG_B_COEFF;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.x_offset   = '0;
      req_if.y_offset   = '0;
      rsp_if.ready      = 1'b0;
      cfg_b             = B_RESET;
      cfg_c             = C_RESET;
      cfg_inv_x         = INV_RESET;
      cfg_inv_y         = INV_RESET;
      pairs_outstanding = 0;
      mismatches        = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset kernel, width 0.25: argument is half the offset
      push_pair(0, 0);
      push_pair(32767, 32767);
      push_pair(-32768, -32768);
      push_pair(32767, -32768);
      push_pair(8192, -8192);
      push_pair(8193, 8194);
      push_pair(-8194, -8193);
      push_pair(16383, -16383);
      push_pair(16384, 0);
      push_pair(0, -16384);
      push_pair(4096, -4096);
      push_pair(1, -1);
      push_pair(-1, 1);
      push_pair(12288, 2048);
      push_pair(-20000, 100);
      push_pair(8191, 16385);

      run_phase(16'd0, 16'd2048, 16'd2048, 16'd2048);
      run_phase(16'd4096, 16'd0, 16'd4096, 16'd1024);
      run_phase(16'h8000, 16'h7fff, 16'hffff, 16'h0000);
      run_phase(16'h7fff, 16'h8000, 16'h0000, 16'hffff);
      for (int i = 0; i < 5; i++)
         run_phase(($urandom_range(0, 3) == 0) ? CFG_W'($urandom())
                                               : CFG_W'($urandom_range(0, 8192)),
                   ($urandom_range(0, 3) == 0) ? CFG_W'($urandom())
                                               : CFG_W'($urandom_range(0, 8192)),
                   ($urandom_range(0, 3) == 0) ? CFG_W'($urandom())
                                               : CFG_W'($urandom_range(256, 4096)),
                   ($urandom_range(0, 3) == 0) ? CFG_W'($urandom())
                                               : CFG_W'($urandom_range(256, 4096)));

      wait_drained();
      repeat (NUM_STG + 4) @(posedge clock);
      if (mismatches == 0 && expected_weights.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
